[sv/bxf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_pkg
// Shared types and constants of the 3x3 box mean filter: sample and index
// types, register indexes, and the fixed-point constants of the divide by 9.
// ----------------------------------------------------------------------------
package bxf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int CNT_W     = 11;
	localparam int CELL_W    = 10;
	localparam int CFG_IDX_W = 4;

	// nine 16-bit terms need four extra bits
	localparam int SUM_W = SAMPLE_W + 4;
	// |sum| + rounding bias stays below 2^19
	localparam int MAG_W = 19;

	// x / 9 == (x * RECIP) >> RECIP_SHIFT for every x below 2^MAG_W
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 23;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP      = 20'd932068;
	localparam logic [MAG_W-1:0]   ROUND_BIAS = 19'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [CELL_W-1:0]          cell_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CNT_W-1:0]           cfg_data_t;

	localparam cfg_idx_t REG_RASTER_WIDTH  = 4'd0;
	localparam cfg_idx_t REG_RASTER_HEIGHT = 4'd1;
	localparam cnt_t     GEOM_RESET        = 11'd1024;
	localparam cnt_t     WINDOW_MIN        = 11'd3;

	typedef struct packed {
		cell_t row;
		cell_t column;
		logic  frame_done;
	} cell_meta_t;

endpackage

[sv/bxf_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_intf
// Valid/ready channels of the box mean filter: raster samples in, interior
// cell means out, and the register write channel.
// ----------------------------------------------------------------------------
interface bxf_sample_if import bxf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface bxf_result_if import bxf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t mean_value;
	cell_t   cell_row;
	cell_t   cell_column;
	logic    frame_done;

	modport source(output valid, output mean_value, output cell_row,
		output cell_column, output frame_done, input ready);
	modport sink(input valid, input mean_value, input cell_row,
		input cell_column, input frame_done, output ready);
endinterface

interface bxf_cfg_if import bxf_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[sv/box_filter_3x3_mean_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_unit
// Streaming 3x3 mean filter over a row-major raster of signed Q8.8 samples.
// Takes one sample word per clock unless the result side stalls. Once a
// sample at row r >= 2 and column c >= 2 is taken, a word for interior cell
// (r-1, c-1) leaves through the sum, magnitude, reciprocal multiply and
// output registers: the rounded mean of its nine neighbors, with row,
// column and a last-cell flag. Border cells give no word. The rate of one
// sample a cycle is set by the two line memories, each read and written once
// per cycle. A geometry above MAX_WIDTH/MAX_HEIGHT is clamped, a raster
// smaller than 3x3 gives nothing, and a width or height write restarts
// the frame. The line memories need no clearing after reset.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean_unit import bxf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input logic         clk,
	input logic         arst_n,
	bxf_cfg_if.sink     cfg,
	bxf_sample_if.sink  pixels,
	bxf_result_if.source results
);

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration
	cnt_t width_q, height_q;
	cnt_t eff_w, eff_h;
	logic cfg_we, cfg_hit;

	// raster position
	cnt_t col_q, row_q, col_nx, row_nx;
	logic small_raster, bail, take, emit, col_last, row_last;

	// line memories and window
	sample_t older_mem [MAX_WIDTH];
	sample_t newer_mem [MAX_WIDTH];
	sample_t top_q, mid_q;
	sample_t win_q [6];
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic mem_we;

	// pipeline
	logic signed [SUM_W-1:0] sum_c, sum_s1;
	logic [SUM_W-1:0] abs_c;
	cell_meta_t meta_c, meta_s1, meta_s2, meta_s3;
	logic v_s1, v_s2, v_s3, out_v_q;
	logic rdy1, rdy2, rdy3, rdy_out;
	logic neg_s2, neg_s3;
	logic [MAG_W-1:0] mag_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [SAMPLE_W-1:0] quot_c;
	sample_t mean_q;
	cell_meta_t meta_q;

	// register writes, always taken
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_we &&
		(cfg.index == REG_RASTER_WIDTH || cfg.index == REG_RASTER_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GEOM_RESET;
			height_q <= GEOM_RESET;
		end else if (cfg_we) begin
			unique case (cfg.index)
				REG_RASTER_WIDTH:  width_q  <= cfg.data;
				REG_RASTER_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp geometry to the memory size
	assign eff_w = (32'(width_q) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : width_q;
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) : height_q;

	// decode position of the incoming word
	assign small_raster = (eff_w < WINDOW_MIN) || (eff_h < WINDOW_MIN);
	assign bail     = small_raster || (col_q >= eff_w) || (row_q >= eff_h);
	assign take     = pixels.valid && pixels.ready;
	assign col_last = (col_q == eff_w - CNT_W'(1));
	assign row_last = (row_q == eff_h - CNT_W'(1));
	assign emit     = !bail && (row_q >= CNT_W'(2)) && (col_q >= CNT_W'(2));
	assign mem_we   = take && !bail;

	// advance counters, wrap at row and frame end
	always_comb begin
		col_nx = col_q;
		row_nx = row_q;
		priority if (cfg_hit) begin
			col_nx = '0;
			row_nx = '0;
		end else if (take && bail) begin
			col_nx = '0;
			row_nx = '0;
		end else if (take && col_last) begin
			col_nx = '0;
			row_nx = row_last ? '0 : row_q + CNT_W'(1);
		end else if (take) begin
			col_nx = col_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	// line memories: read ahead at the next column, write the current one
	assign rd_addr = ADDR_W'(col_nx);
	assign wr_addr = ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			older_mem[wr_addr] <= mid_q;
			newer_mem[wr_addr] <= pixels.sample;
		end
		top_q <= older_mem[rd_addr];
		mid_q <= newer_mem[rd_addr];
	end

	// shift the window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (mem_we) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_q;
			win_q[4] <= mid_q;
			win_q[5] <= pixels.sample;
		end
	end

	// nine-term sum and cell position
	assign sum_c = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
		+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5])
		+ SUM_W'(top_q) + SUM_W'(mid_q) + SUM_W'(pixels.sample);
	assign meta_c.row        = CELL_W'(row_q - CNT_W'(1));
	assign meta_c.column     = CELL_W'(col_q - CNT_W'(1));
	assign meta_c.frame_done = row_last && col_last;

	// stall chain: a stage loads when empty or when its word moves on
	assign rdy_out      = !out_v_q || results.ready;
	assign rdy3         = !v_s3 || rdy_out;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign pixels.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1    <= take && emit;
			if (rdy2)    v_s2    <= v_s1;
			if (rdy3)    v_s3    <= v_s2;
			if (rdy_out) out_v_q <= v_s3;
		end
	end

	// magnitude plus rounding bias, then reciprocal multiply
	assign abs_c  = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
	assign quot_c = prod_s3[RECIP_SHIFT +: SAMPLE_W];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sum_s1  <= sum_c;
			meta_s1 <= meta_c;
		end
		if (rdy2) begin
			neg_s2  <= sum_s1[SUM_W-1];
			mag_s2  <= MAG_W'(abs_c) + ROUND_BIAS;
			meta_s2 <= meta_s1;
		end
		if (rdy3) begin
			neg_s3  <= neg_s2;
			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(RECIP);
			meta_s3 <= meta_s2;
		end
		if (rdy_out) begin
			mean_q <= neg_s3 ? sample_t'(-quot_c) : sample_t'(quot_c);
			meta_q <= meta_s3;
		end
	end

	// drive the result channel from the output register
	assign results.valid       = out_v_q;
	assign results.mean_value  = mean_q;
	assign results.cell_row    = meta_q.row;
	assign results.cell_column = meta_q.column;
	assign results.frame_done  = meta_q.frame_done;

	// a raster below 3x3 keeps the position at the origin
	a_small_holds_origin: assert property (@(posedge clk) disable iff (!arst_n)
		take && small_raster |=> col_q == '0 && row_q == '0)
		else $error("position moved on a raster below 3x3");

	// a geometry write restarts the frame
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> col_q == '0 && row_q == '0)
		else $error("register write did not restart the frame");

	// position stays inside the raster or at its origin
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == '0 || col_q < eff_w) && (row_q == '0 || row_q < eff_h))
		else $error("raster position outside the geometry");

endmodule

[bench/bxf_mean_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxf_mean_check
// Watches the register, sample and result channels of the 3x3 box mean
// filter. Keeps its own line rows, window and raster position, predicts the
// mean word of every interior cell, and compares each result word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bxf_mean_check import bxf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	bxf_cfg_if    cfg,
	bxf_sample_if pix,
	bxf_result_if res,
	output int    mismatches,
	output int    cells_waiting
);

	typedef struct packed {
		sample_t mean;
		cell_t   row;
		cell_t   column;
		logic    frame_end;
	} cell_mean_t;

	cnt_t       raster_w;
	cnt_t       raster_h;
	sample_t    older_row [MAX_WIDTH];
	sample_t    newer_row [MAX_WIDTH];
	sample_t    win [6];
	int         col;
	int         row;
	int         fault_count;
	cell_mean_t expected_means [$];

	assign mismatches = fault_count;

	// Advance the raster by one sample; queue the mean of the interior cell
	// it completes, if any.
	function automatic void take_sample(input sample_t s);
		int          w;
		int          h;
		sample_t     above2;
		sample_t     above1;
		int          sum;
		int unsigned mag;
		int unsigned q;
		cell_mean_t  mc;
		w = (raster_w > MAX_WIDTH) ? MAX_WIDTH : int'(raster_w);
		h = (raster_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(raster_h);
		// rasters below 3x3 store nothing and hold the position at origin
		if (w < WINDOW_MIN || h < WINDOW_MIN || col >= w || row >= h) begin
			col = 0;
			row = 0;
			return;
		end
		above2 = older_row[col];
		above1 = newer_row[col];
		if (row >= 2 && col >= 2) begin
			sum = int'(s) + int'(above1) + int'(above2);
			for (int i = 0; i < 6; i++)
				sum += int'(win[i]);
			// divide by 9, round half away from zero on the magnitude
			mag = (sum < 0) ? -sum : sum;
			q = (mag + 4) / 9;
			mc.mean      = sample_t'((sum < 0) ? -int'(q) : int'(q));
			mc.row       = cell_t'(row - 1);
			mc.column    = cell_t'(col - 1);
			mc.frame_end = (row == h - 1) && (col == w - 1);
			expected_means.push_back(mc);
		end
		older_row[col] = above1;
		newer_row[col] = s;
		// shift the window one column left
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = above2;
		win[4] = above1;
		win[5] = s;
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h)
				row = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_mean_t want;
		if (!arst_n) begin
			raster_w = GEOM_RESET;
			raster_h = GEOM_RESET;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				win[i] = '0;
			col = 0;
			row = 0;
			fault_count = 0;
			expected_means.delete();
			cells_waiting <= 0;
		end else begin
			// register write: known index restarts the frame, others drop
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_RASTER_WIDTH: begin
						raster_w = cfg.data;
						col = 0;
						row = 0;
					end
					REG_RASTER_HEIGHT: begin
						raster_h = cfg.data;
						col = 0;
						row = 0;
					end
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				take_sample(pix.sample);
			// compare each result word with the oldest prediction
			if (res.valid && res.ready) begin
				if (expected_means.size() == 0) begin
					$error("result word with no prediction: row %0d column %0d mean %0d",
						res.cell_row, res.cell_column, res.mean_value);
					fault_count++;
				end else begin
					want = expected_means.pop_front();
					if (res.mean_value !== want.mean) begin
						$error("mean_value: expected %0d, got %0d", want.mean,
							res.mean_value);
						fault_count++;
					end
					if (res.cell_row !== want.row) begin
						$error("cell_row: expected %0d, got %0d", want.row, res.cell_row);
						fault_count++;
					end
					if (res.cell_column !== want.column) begin
						$error("cell_column: expected %0d, got %0d", want.column,
							res.cell_column);
						fault_count++;
					end
					if (res.frame_done !== want.frame_end) begin
						$error("frame_done: expected %0b, got %0b", want.frame_end,
							res.frame_done);
						fault_count++;
					end
				end
			end
			cells_waiting <= expected_means.size();
		end
	end

endmodule

[bench/tb_box_filter_3x3_mean_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_mean_unit
// Streams rasters through the 3x3 box mean filter under many geometries:
// full-scale values, rasters below 3x3, frame wrap, oversized width and height,
// and writes to unused register indexes. Both channels idle at random. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_mean_unit;
	import bxf_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 1024;
	localparam int RANDOM_ITEMS = 500;
	// short stretch of samples under an oversized geometry
	localparam int CLAMP_ITEMS  = 40;
	// pause that lets the pipeline empty before a register write
	localparam int DRAIN_CYCLES = 12;
	// longest correct quiet stretch: the longest result stall on a full pipe,
	// the longest sample gap, or a drain pause; allow far more than any of them
	localparam int QUIET_LIMIT  = 1000;

	typedef enum {VAL_ANY, VAL_EXTREME, VAL_SMALL, VAL_RAIL} value_mix_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   cells_waiting;
	int   quiet_cycles;
	int   cells_seen;
	int   samples_sent;
	int   geometries;
	bit   steady;

	bxf_cfg_if    cfg ();
	bxf_sample_if pix ();
	bxf_result_if res ();

	box_filter_3x3_mean_unit #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixels (pix),
		.results(res)
	);

	bxf_mean_check #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) mean_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pix          (pix),
		.res          (res),
		.mismatches   (mismatches),
		.cells_waiting(cells_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hold off a cycle count with nothing accepted anywhere; stop on a hang.
	always @(posedge clk) begin
		if (!arst_n || (cfg.valid && cfg.ready) || (pix.valid && pix.ready)
			|| (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_box_filter_3x3_mean_unit: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (arst_n && res.valid && res.ready)
			cells_seen <= cells_seen + 1;
	end

	// Result side: ready runs of random length, short stalls, rare long ones.
	initial begin : result_drain
		int hold;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			hold = ($urandom_range(19) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			res.ready <= 1'b1;
			repeat (hold) @(posedge clk);
			case ($urandom_range(99)) inside
				[0:49]:  hold = 0;
				[50:84]: hold = $urandom_range(1, 3);
				[85:96]: hold = $urandom_range(4, 12);
				default: hold = $urandom_range(20, 60);
			endcase
			if (hold > 0) begin
				res.ready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end
		end
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic sample_t pick_sample(input value_mix_t mix);
		case (mix)
			VAL_EXTREME: begin
				case ($urandom_range(4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return sample_t'($urandom);
				endcase
			end
			VAL_SMALL: return sample_t'(int'($urandom_range(0, 40)) - 20);
			VAL_RAIL: begin
				if ($urandom_range(1))
					return sample_t'(32767 - int'($urandom_range(0, 15)));
				return sample_t'(-32768 + int'($urandom_range(0, 15)));
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offer one sample word after a random gap and hold until it is taken.
	task automatic push_sample(input sample_t v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid  <= 1'b1;
		pix.sample <= v;
		do @(posedge clk); while (!pix.ready);
		samples_sent++;
	endtask

	// Write one register; lower valid only after the last word of a burst.
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val,
		input bit last_word);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (last_word)
			cfg.valid <= 1'b0;
	endtask

	task automatic set_geometry(input cfg_data_t w, input cfg_data_t h);
		if ($urandom_range(1)) begin
			write_reg(REG_RASTER_WIDTH, w, 1'b0);
			write_reg(REG_RASTER_HEIGHT, h, 1'b1);
		end else begin
			write_reg(REG_RASTER_HEIGHT, h, 1'b0);
			write_reg(REG_RASTER_WIDTH, w, 1'b1);
		end
		geometries++;
	endtask

	// Wait until every predicted word has left, then let the pipe empty.
	task automatic settle();
		do @(posedge clk); while (cells_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Send n samples; at spare_at, pause and write an unused register index.
	task automatic feed(input int n, input value_mix_t mix, input int spare_at);
		for (int i = 0; i < n; i++) begin
			if (i == spare_at) begin
				pix.valid <= 1'b0;
				settle();
				write_reg(cfg_idx_t'($urandom_range(REG_RASTER_HEIGHT + 1, 15)),
					cfg_data_t'($urandom), 1'b1);
			end
			push_sample(pick_sample(mix));
		end
		pix.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int         roll;
		int         w;
		int         h;
		int         n;
		int         random_sent;
		value_mix_t mix;
		arst_n       <= 1'b0;
		cfg.valid    <= 1'b0;
		cfg.index    <= '0;
		cfg.data     <= '0;
		pix.valid    <= 1'b0;
		pix.sample   <= '0;
		quiet_cycles <= 0;
		cells_seen   <= 0;
		samples_sent = 0;
		geometries   = 0;
		random_sent  = 0;
		steady       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: a few samples on row 0 give nothing
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sh0000);
		pix.valid <= 1'b0;
		settle();
		// two 3x3 frames back to back: positive rail, then negative rail
		set_geometry(11'd3, 11'd3);
		for (int i = 0; i < 9; i++)
			push_sample(16'sh7FFF);
		for (int i = 0; i < 9; i++)
			push_sample(16'sh8000);
		pix.valid <= 1'b0;
		settle();
		// width below 3: samples are taken but nothing comes out
		write_reg(REG_RASTER_WIDTH, 11'd2, 1'b1);
		for (int i = 0; i < 4; i++)
			push_sample(pick_sample(VAL_ANY));
		pix.valid <= 1'b0;
		settle();

		// random geometries, mostly whole frames with a partial tail
		while (random_sent < RANDOM_ITEMS) begin
			roll   = $urandom_range(99);
			steady = ($urandom_range(4) == 0);
			mix    = value_mix_t'($urandom_range(3));
			if (roll < 12) begin
				w = $urandom_range(0, 4);
				h = (w < 3) ? $urandom_range(0, 6) : $urandom_range(0, 2);
				n = $urandom_range(4, 16);
			end else begin
				w = (roll > 94) ? $urandom_range(11, 40) : $urandom_range(3, 10);
				h = $urandom_range(3, 6);
				n = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h - 1);
			end
			// keep the total near the sample budget
			if (n > RANDOM_ITEMS - random_sent)
				n = RANDOM_ITEMS - random_sent;
			random_sent += n;
			set_geometry(cfg_data_t'(w), cfg_data_t'(h));
			feed(n, mix, ($urandom_range(3) == 0) ? $urandom_range(1, n - 1) : -1);
			settle();
		end

		// width above the line length: a short stretch on the first row
		steady = 1'b0;
		set_geometry(11'd2047, 11'd3);
		feed(CLAMP_ITEMS, VAL_ANY, -1);
		settle();
		// height above the frame limit on a narrow raster: a short stretch
		set_geometry(11'd3, 11'd1500);
		feed(CLAMP_ITEMS, VAL_ANY, -1);
		settle();

		$display("sent %0d samples under %0d geometries, checked %0d interior means",
			samples_sent, geometries, cells_seen);
		$display("covered rails, sub-3x3 rasters, frame wrap, oversized sizes, unused indexes");
		if (mismatches == 0 && cells_waiting == 0) begin
			$display("tb_box_filter_3x3_mean_unit: clean");
		end else begin
			if (cells_waiting != 0)
				$error("%0d predicted means never arrived", cells_waiting);
			$display("tb_box_filter_3x3_mean_unit: errors");
		end
		$finish;
	end

endmodule
